FILE: rtl/core/mvm_pkg.sv
// Shared constants and types for the matrix-vector multiply block.
package mvm_pkg;

    localparam int MAX_SIZE_DEFAULT     = 1024;
    localparam int ELEMENT_BITS_DEFAULT = 16;
    localparam int SIZE_RESET           = 1024;
    localparam int SIZE_BITS            = 11;
    localparam int INDEX_BITS           = 10;
    localparam int VALUE_BITS           = 16;
    localparam int ROW_BITS             = 10;
    localparam int ACC_BITS             = 48;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    typedef struct packed {
        logic                row_end;
        logic                last_row;
        logic [ROW_BITS-1:0] row_number;
    } mvm_ctrl_t;

endpackage

FILE: rtl/core/mvm_front.sv
// Front end: takes requests, holds the vector store, tracks row and column.
module mvm_front
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE     = MAX_SIZE_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [SIZE_BITS-1:0]           cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_command,
    input  logic [INDEX_BITS-1:0]          in_index,
    input  logic signed [VALUE_BITS-1:0]   in_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mvm_ctrl_t                      out_ctrl,
    output logic signed [ELEMENT_BITS-1:0] out_elem,
    output logic signed [ELEMENT_BITS-1:0] out_vec
);

    localparam int AW         = $clog2(MAX_SIZE);
    localparam int RESET_LAST = ((SIZE_RESET < MAX_SIZE) ? SIZE_RESET : MAX_SIZE) - 1;

    logic signed [ELEMENT_BITS-1:0] vec_mem [MAX_SIZE];

    logic [AW-1:0]  col_reg, col_next;
    logic [AW-1:0]  row_reg, row_next;
    logic [AW-1:0]  last_idx_reg, last_idx_next;
    logic           f_valid_reg;
    mvm_ctrl_t      ctrl_reg;
    logic signed [ELEMENT_BITS-1:0] elem_reg;
    logic signed [ELEMENT_BITS-1:0] vec_reg;

    logic signed [ELEMENT_BITS-1:0] elem;
    logic           accept;
    logic           is_matrix;
    logic           row_end;
    logic           last_row;
    logic           index_ok;

    generate
        if (ELEMENT_BITS <= VALUE_BITS) begin : g_narrow
            assign elem = in_value[ELEMENT_BITS-1:0];
        end
        else begin : g_wide
            assign elem = ELEMENT_BITS'($unsigned(in_value));
        end
    endgenerate

    assign in_ready  = !f_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_matrix = (in_command == CMD_MATRIX);
    assign row_end   = (col_reg == last_idx_reg);
    assign last_row  = (row_reg == last_idx_reg);
    assign index_ok  = (32'(in_index) < MAX_SIZE);

    // size 0 acts as 1, oversize acts as MAX_SIZE
    always_comb
    begin
        if (cfg_wr_data == '0)
            last_idx_next = '0;
        else if (32'(cfg_wr_data) > MAX_SIZE)
            last_idx_next = AW'(MAX_SIZE - 1);
        else
            last_idx_next = AW'(cfg_wr_data - SIZE_BITS'(1));
    end

    always_comb
    begin
        col_next = row_end ? '0 : col_reg + AW'(1);
        row_next = row_reg;
        if (row_end)
            row_next = last_row ? '0 : row_reg + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_idx_reg <= AW'(RESET_LAST);
            f_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                last_idx_reg <= last_idx_next;
            end
            else if (accept && is_matrix)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready)
                f_valid_reg <= accept && is_matrix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_matrix && index_ok)
            vec_mem[AW'(in_index)] <= elem;
        if (accept && is_matrix)
        begin
            vec_reg  <= vec_mem[col_reg];
            elem_reg <= elem;
            ctrl_reg <= '{row_end: row_end, last_row: last_row,
                          row_number: ROW_BITS'(row_reg)};
        end
    end

    assign out_valid = f_valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_elem  = elem_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: rtl/core/mvm_fifo.sv
// Short queue between front end and multiply-accumulate back end.
module mvm_fifo
    import mvm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/core/mvm_back.sv
// Back end: product register, row accumulator and output register.
module mvm_back
    import mvm_pkg::*;
#(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mvm_ctrl_t                      in_ctrl,
    input  logic signed [ELEMENT_BITS-1:0] in_elem,
    input  logic signed [ELEMENT_BITS-1:0] in_vec,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ROW_BITS-1:0]            out_row,
    output logic signed [ACC_BITS-1:0]     out_dot,
    output logic                           out_last
);

    logic                             p_valid_reg;
    mvm_ctrl_t                        p_ctrl_reg;
    logic signed [2*ELEMENT_BITS-1:0] prod_reg;
    logic signed [ACC_BITS-1:0]       acc_reg;
    logic                             out_valid_reg;
    logic [ROW_BITS-1:0]              out_row_reg;
    logic signed [ACC_BITS-1:0]       out_dot_reg;
    logic                             out_last_reg;

    logic                             out_free;
    logic                             p_adv;
    logic signed [ACC_BITS-1:0]       sum;

    assign out_free = !out_valid_reg || out_ready;
    // a row-end product waits only for a free output register
    assign p_adv    = p_valid_reg && (!p_ctrl_reg.row_end || out_free);
    assign in_ready = !p_valid_reg || p_adv;
    assign sum      = acc_reg + ACC_BITS'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                p_valid_reg <= in_valid;
            if (restart)
                acc_reg <= '0;
            else if (p_adv)
                acc_reg <= p_ctrl_reg.row_end ? '0 : sum;
            if (p_adv && p_ctrl_reg.row_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg   <= in_elem * in_vec;
            p_ctrl_reg <= in_ctrl;
        end
        if (p_adv && p_ctrl_reg.row_end)
        begin
            out_row_reg  <= p_ctrl_reg.row_number;
            out_dot_reg  <= sum;
            out_last_reg <= p_ctrl_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_dot   = out_dot_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/core/matrix_vector_multiply.sv
// Top level of the matrix-vector multiply block.
//
//  channel   direction  payload
//  s_axis    in         tdata: vector_index, element_value; tuser: command
//  m_axis    out        tdata: row_number, dot_product; tlast: last_row
//  cfg       in         cfg_wr_data: matrix_size
//
// One request per cycle sustained while the queue has room, loads and matrix elements alike.
// A row's final element reaches its result through store read, queue, product register
// and output register.
// Reset clears counters, accumulator and queue; the vector store is not cleared.
// The queue lets the front end keep taking requests while the output stalls.
module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int MAX_SIZE     = MAX_SIZE_DEFAULT,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [SIZE_BITS-1:0] cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // vector_index[9:0], element_value[25:10]
    input  logic [0:0]           s_axis_tuser,   // command[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // row_number[9:0], dot_product[57:10]
    output logic                 m_axis_tlast
);

    localparam int QW = $bits(mvm_ctrl_t) + 2 * ELEMENT_BITS;

    logic                           f_valid;
    logic                           q_ready;
    mvm_ctrl_t                      f_ctrl;
    logic signed [ELEMENT_BITS-1:0] f_elem;
    logic signed [ELEMENT_BITS-1:0] f_vec;
    logic                           b_valid;
    logic                           b_ready;
    logic [QW-1:0]                  b_data;
    mvm_ctrl_t                      b_ctrl;
    logic signed [ELEMENT_BITS-1:0] b_elem;
    logic signed [ELEMENT_BITS-1:0] b_vec;
    logic [ROW_BITS-1:0]            out_row;
    logic signed [ACC_BITS-1:0]     out_dot;

    mvm_front #(
        .MAX_SIZE     (MAX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_command  (s_axis_tuser[0]),
        .in_index    (s_axis_tdata[INDEX_BITS-1:0]),
        .in_value    (s_axis_tdata[INDEX_BITS+VALUE_BITS-1:INDEX_BITS]),
        .out_valid   (f_valid),
        .out_ready   (q_ready),
        .out_ctrl    (f_ctrl),
        .out_elem    (f_elem),
        .out_vec     (f_vec)
    );

    mvm_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (q_ready),
        .push_data  ({f_ctrl, f_vec, f_elem}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_ctrl, b_vec, b_elem} = b_data;

    mvm_back #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_wr_en),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_ctrl   (b_ctrl),
        .in_elem   (b_elem),
        .in_vec    (b_vec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_dot   (out_dot),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_dot, out_row};

    // front end stalls only when its held element cannot enter the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (f_valid && !q_ready))
        else $error("input stalled without a full queue");

    // a held front-end element must not change while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && !q_ready) |=> (f_valid && $stable(f_ctrl) && $stable(f_elem)))
        else $error("front-end element lost while queue full");

    // a stalled result holds its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the matrix_vector_multiply block.
`timescale 1ns / 1ps

module testbench
    import mvm_pkg::*;
();

    localparam int  STORE_DEPTH  = 1024;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  CYCLE_LIMIT  = 1000000;

    typedef enum logic [1:0] {STEP_SIZE, STEP_LOAD, STEP_ELEM} step_kind_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [ACC_BITS-1:0] dot;
        logic                last;
    } row_result_t;

    typedef struct {
        step_kind_t          kind;
        int                  num;
        logic [VALUE_BITS-1:0] value;
        bit                  typed;
        row_result_t         want;
    } step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [SIZE_BITS-1:0]   cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata;   // vector_index[9:0], element_value[25:10]
    logic [0:0]             s_axis_tuser;   // command[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [63:0]            m_axis_tdata;   // row_number[9:0], dot_product[57:10]
    logic                   m_axis_tlast;

    matrix_vector_multiply dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the block's state
    logic [VALUE_BITS-1:0]  vec_mem [0:STORE_DEPTH-1];
    bit                     vec_loaded [0:STORE_DEPTH-1];
    logic [SIZE_BITS-1:0]   size_reg;
    int                     col_count;
    int                     row_count;
    logic [ACC_BITS-1:0]    row_acc;

    row_result_t            pending_rows[$];
    step_t                  directed_steps[$];

    int                     fail_count;
    int                     n_requests;
    int                     n_loads;
    int                     n_rows;
    int                     n_size_writes;
    int                     burst_left;
    int                     cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int size_in_use();
        if (size_reg == 0)
            return 1;
        if (size_reg > STORE_DEPTH)
            return STORE_DEPTH;
        return int'(size_reg);
    endfunction

    // Row dot-product predictor: returns 1 when the request closes a row.
    function automatic bit mac_step(input logic cmd, input logic [INDEX_BITS-1:0] idx,
                                    input logic [VALUE_BITS-1:0] val,
                                    output row_result_t res);
        int     n;
        int     col;
        longint prod;
        res = '0;
        if (cmd == CMD_LOAD)
        begin
            vec_mem[idx]    = val;
            vec_loaded[idx] = 1'b1;
            return 1'b0;
        end
        n   = size_in_use();
        col = col_count;
        if (col >= n)
            col = 0;
        if (row_count >= n)
            row_count = 0;
        prod    = longint'($signed(val)) * longint'($signed(vec_mem[col]));
        row_acc = row_acc + prod[ACC_BITS-1:0];
        if (col + 1 < n)
        begin
            col_count = col + 1;
            return 1'b0;
        end
        res.row   = row_count[ROW_BITS-1:0];
        res.dot   = row_acc;
        res.last  = (row_count + 1 == n);
        col_count = 0;
        row_acc   = '0;
        row_count = (row_count + 1 < n) ? row_count + 1 : 0;
        return 1'b1;
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_request(input logic cmd, input logic [INDEX_BITS-1:0] idx,
                                input logic [VALUE_BITS-1:0] val,
                                input bit typed, input row_result_t want);
        int          gap;
        row_result_t res;
        bit          has_row;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        has_row = mac_step(cmd, idx, val, res);
        if (typed)
            pending_rows.push_back(want);
        else if (has_row)
            pending_rows.push_back(res);
        n_requests++;
        if (cmd == CMD_LOAD)
            n_loads++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input int value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[SIZE_BITS-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        size_reg  = value[SIZE_BITS-1:0];
        col_count = 0;
        row_count = 0;
        row_acc   = '0;
        n_size_writes++;
    endtask

    task automatic add_step(input step_kind_t kind, input int num, input int value,
                            input int typed, input int row, input longint dot,
                            input int last);
        step_t s;
        s.kind       = kind;
        s.num        = num;
        s.value      = value[VALUE_BITS-1:0];
        s.typed      = (typed != 0);
        s.want.row   = row[ROW_BITS-1:0];
        s.want.dot   = dot[ACC_BITS-1:0];
        s.want.last  = (last != 0);
        directed_steps.push_back(s);
    endtask

    function automatic logic [VALUE_BITS-1:0] rand_element();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            default: return VALUE_BITS'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // One size setting: make every used entry valid, then mostly matrix elements.
    task automatic run_phase(input int size_val, input int n_items);
        int n;
        int r;
        int hold_at;
        write_size(size_val);
        n = size_in_use();
        for (int k = 0; k < n; k++)
            if (!vec_loaded[k])
                send_request(CMD_LOAD, INDEX_BITS'(k), rand_element(), 1'b0, '0);
        hold_at = $urandom_range(0, n_items - 1);
        for (int i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 12)
                send_request(CMD_LOAD, INDEX_BITS'($urandom_range(0, n - 1)), rand_element(),
                             1'b0, '0);
            else if (r < 17)
                send_request(CMD_LOAD, INDEX_BITS'($urandom_range(0, STORE_DEPTH - 1)),
                             rand_element(), 1'b0, '0);
            else
                send_request(CMD_MATRIX, INDEX_BITS'($urandom_range(0, STORE_DEPTH - 1)),
                             rand_element(), 1'b0, '0);
        end
    endtask

    // Receiver stalls: switches between always ready, coin flip and mostly stalled.
    int rx_mode;
    int rx_left;
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        row_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("unexpected row result: row %0d", m_axis_tdata[9:0]);
                fail_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                n_rows++;
                if (m_axis_tdata[9:0] !== want.row)
                begin
                    $error("row_number: expected %0d, got %0d", want.row, m_axis_tdata[9:0]);
                    fail_count++;
                end
                if (m_axis_tdata[57:10] !== want.dot)
                begin
                    $error("dot_product: expected %0d, got %0d", $signed(want.dot),
                           $signed(m_axis_tdata[57:10]));
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_row: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("matrix_vector_multiply: mismatch");
            $finish;
        end
    end

    initial
    begin
        step_t s;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        n_requests    = 0;
        n_loads       = 0;
        n_size_writes = 0;
        burst_left    = 0;
        size_reg      = SIZE_BITS'(SIZE_RESET);
        col_count     = 0;
        row_count     = 0;
        row_acc       = '0;
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            vec_mem[k]    = '0;
            vec_loaded[k] = 1'b0;
        end

        // Loads at reset size, extremes, load during a row, size zero, pass wrap
        add_step(STEP_LOAD, 1023, -1, 0, 0, 0, 0);
        add_step(STEP_LOAD, 512, 0, 0, 0, 0, 0);
        add_step(STEP_SIZE, 2, 0, 0, 0, 0, 0);
        add_step(STEP_LOAD, 0, 32767, 0, 0, 0, 0);
        add_step(STEP_LOAD, 1, -32768, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, -32768, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, -32768, 1, 0, 32768, 0);
        add_step(STEP_ELEM, 0, 32767, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, 32767, 1, 1, -32767, 1);
        add_step(STEP_ELEM, 0, 1, 0, 0, 0, 0);
        add_step(STEP_LOAD, 1, 5, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, 1, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, 9, 0, 0, 0, 0);
        add_step(STEP_SIZE, 0, 0, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, -32768, 1, 0, -1073709056, 1);
        add_step(STEP_ELEM, 0, 32767, 1, 0, 1073676289, 1);
        add_step(STEP_SIZE, 1, 0, 0, 0, 0, 0);
        add_step(STEP_LOAD, 0, -1, 0, 0, 0, 0);
        add_step(STEP_ELEM, 0, -32768, 1, 0, 32768, 1);
        add_step(STEP_SIZE, 3, 0, 0, 0, 0, 0);
        add_step(STEP_LOAD, 2, 100, 0, 0, 0, 0);
        for (int k = 0; k < 10; k++)
            add_step(STEP_ELEM, 0, k - 3, 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            case (s.kind)
                STEP_SIZE: write_size(s.num);
                STEP_LOAD: send_request(CMD_LOAD, INDEX_BITS'(s.num), s.value, s.typed,
                                        s.want);
                default:   send_request(CMD_MATRIX,
                                        INDEX_BITS'($urandom_range(0, STORE_DEPTH - 1)),
                                        s.value, s.typed, s.want);
            endcase
        end

        run_phase(1, 70);
        run_phase(2, 90);
        run_phase(0, 40);
        run_phase(5, 100);
        run_phase($urandom_range(3, 40), 110);
        run_phase(100, 300);
        run_phase(16, 100);
        run_phase($urandom_range(2, 64), 120);
        run_phase(7, 80);
        run_phase($urandom_range(1, 12), 90);

        drain_results();
        $display("run covered %0d requests (%0d vector loads) over %0d size settings",
                 n_requests, n_loads, n_size_writes);
        $display("%0d row results compared, sizes from zero up to one hundred", n_rows);
        if (fail_count == 0)
            $display("matrix_vector_multiply: match");
        else
            $display("matrix_vector_multiply: mismatch");
        $finish;
    end

endmodule
